// ===== hdl/cwc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cwc_pkg: shared types and helpers for the CIGAR window clipper
// Operation and result codes, stage payload structs and saturating arithmetic.
// ----------------------------------------------------------------------------
package cwc_pkg;

  localparam int unsigned CW = 32;  // coordinate and length width
  localparam int unsigned WW = 34;  // signed width of window offset and length

  // Operation kinds as they travel on the streams.
  localparam logic [1:0] KIND_MATCH = 2'd0;
  localparam logic [1:0] KIND_INS   = 2'd1;
  localparam logic [1:0] KIND_DEL   = 2'd2;

  // Result kinds.
  localparam logic RES_OP      = 1'b0;
  localparam logic RES_SUMMARY = 1'b1;

  // One accepted operation with its window already turned into offsets.
  typedef struct packed {
    logic                 first_op;
    logic                 last_op;
    logic [CW-1:0]        op_length;
    logic [1:0]           op_kind;
    logic                 reverse_strand;
    logic [CW-1:0]        orig_target_start;
    logic [CW-1:0]        orig_target_end;
    logic signed [WW-1:0] win_off;
    logic signed [WW-1:0] win_len;
  } cwc_item_t;

  // Running alignment totals that the summary is built from.
  typedef struct packed {
    logic [CW-1:0] target_first_offset;
    logic [CW-1:0] target_kept;
    logic [CW-1:0] match_count;
    logic [CW-1:0] total_count;
    logic          first_offset_set;
  } cwc_state_t;

  // Tracker output: the trimmed operation and the summary request.
  typedef struct packed {
    logic          op_valid;
    logic [CW-1:0] op_length;
    logic [1:0]    op_kind;
    logic          sum_valid;
    logic          reverse_strand;
    logic [CW-1:0] orig_target_start;
    logic [CW-1:0] orig_target_end;
  } cwc_trk_t;

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CW] ? {CW{1'b1}} : s[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] sat_sub(input logic [CW-1:0] a, input logic [CW-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/cwc_in_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cwc_in_stage: input register of the CIGAR window clipper
// Captures one operation per transaction and turns the window into offsets.
// ----------------------------------------------------------------------------
module cwc_in_stage (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [191:0]        in_tdata,
  input  wire logic [3:0]          in_tuser,
  input  wire logic                in_tlast,
  output logic                     s1_valid,
  input  wire logic                s1_ready,
  output cwc_pkg::cwc_item_t       s1_item
);
  import cwc_pkg::*;

  logic            valid_r;
  logic            valid_nxt;
  cwc_item_t       item_r;
  cwc_item_t       item_nxt;
  logic            accept;
  logic [CW-1:0]   aq_start;
  logic [CW-1:0]   keep_start;
  logic [CW-1:0]   keep_end;

  assign in_tready = !valid_r || s1_ready;
  assign accept    = in_tvalid && in_tready;
  assign valid_nxt = accept || (valid_r && !s1_ready);

  assign aq_start   = in_tdata[63:32];
  assign keep_start = in_tdata[95:64];
  assign keep_end   = in_tdata[127:96];

  always_comb begin
    item_nxt.first_op          = in_tuser[0];
    item_nxt.last_op           = in_tlast;
    item_nxt.op_length         = in_tdata[31:0];
    item_nxt.op_kind           = in_tuser[2:1];
    item_nxt.reverse_strand    = in_tuser[3];
    item_nxt.orig_target_start = in_tdata[159:128];
    item_nxt.orig_target_end   = in_tdata[191:160];
    // Window start as an offset into the query; it may lie before the alignment.
    item_nxt.win_off = $signed({2'b00, keep_start}) - $signed({2'b00, aq_start});
    // Window length; zero or negative when the window is empty or inverted.
    item_nxt.win_len = $signed({2'b00, keep_end}) - $signed({2'b00, keep_start})
                       + $signed(WW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule
`default_nettype wire

// ===== hdl/cwc_tracker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cwc_tracker: running offsets and per-operation trimming
// Updates query and target offsets and registers the trimmed operation.
// ----------------------------------------------------------------------------
module cwc_tracker (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                s1_valid,
  output logic                     s1_ready,
  input  wire cwc_pkg::cwc_item_t  s1_item,
  output logic                     s2_valid,
  input  wire logic                s2_ready,
  output cwc_pkg::cwc_trk_t        s2_trk,
  output cwc_pkg::cwc_state_t      s2_state
);
  import cwc_pkg::*;

  logic            valid_r;
  logic            load;
  cwc_trk_t        trk_r;
  cwc_trk_t        trk_nxt;

  logic [CW-1:0]   query_pos_r, query_pos_nxt;
  logic [CW-1:0]   query_kept_r, query_kept_nxt;
  logic [CW-1:0]   target_pos_r, target_pos_nxt;
  logic [CW-1:0]   target_kept_r, target_kept_nxt;
  logic [CW-1:0]   target_first_offset_r, target_first_offset_nxt;
  logic            first_offset_set_r, first_offset_set_nxt;
  logic            inside_window_r, inside_window_nxt;
  logic [CW-1:0]   match_count_r, match_count_nxt;
  logic [CW-1:0]   total_count_r, total_count_nxt;

  // State as seen by this operation: a first operation starts from zero.
  logic [CW-1:0]   qp, qk, tp, tk, tfo, mc, tc;
  logic            fos, win_open;

  logic                 is_m, is_i, is_d, is_mi;
  logic signed [34:0]   qo_s, ql_s, len_s, w_s, l_s;
  logic signed [34:0]   end_s, mx_s, a_s, avail_s, kept_s, lclip_s;
  logic                 hit, before_win, inside_after;
  logic [CW-1:0]        kept, lclip, new_qk;

  assign s1_ready = !valid_r || s2_ready;
  assign load     = s1_valid && s1_ready;

  always_comb begin
    if (s1_item.first_op) begin
      qp = '0; qk = '0; tp = '0; tk = '0; tfo = '0; mc = '0; tc = '0;
      fos = 1'b0; win_open = 1'b0;
    end else begin
      qp = query_pos_r; qk = query_kept_r; tp = target_pos_r; tk = target_kept_r;
      tfo = target_first_offset_r; mc = match_count_r; tc = total_count_r;
      fos = first_offset_set_r; win_open = inside_window_r;
    end
  end

  always_comb begin
    is_m  = (s1_item.op_kind == KIND_MATCH);
    is_i  = (s1_item.op_kind == KIND_INS);
    is_d  = (s1_item.op_kind == KIND_DEL);
    is_mi = is_m || is_i;

    qo_s  = $signed({3'b000, qp});
    ql_s  = $signed({3'b000, qk});
    len_s = $signed({3'b000, s1_item.op_length});
    w_s   = $signed({s1_item.win_off[WW-1], s1_item.win_off});
    l_s   = $signed({s1_item.win_len[WW-1], s1_item.win_len});

    end_s      = qo_s + len_s;
    hit        = (end_s > w_s) && (ql_s < l_s);
    before_win = (qo_s < w_s);
    // Part of the operation past the window start, then capped by what is left.
    mx_s    = before_win ? w_s : qo_s;
    a_s     = end_s - mx_s;
    avail_s = l_s - ql_s;
    kept_s  = (a_s < avail_s) ? a_s : avail_s;
    kept    = kept_s[CW-1:0];
    lclip_s = w_s - qo_s;
    lclip   = before_win ? lclip_s[CW-1:0] : '0;

    new_qk       = sat_add(qk, kept);
    inside_after = hit && ($signed({3'b000, new_qk}) < l_s);

    query_pos_nxt           = is_mi ? sat_add(qp, s1_item.op_length) : qp;
    query_kept_nxt          = (is_mi && hit) ? new_qk : qk;
    total_count_nxt         = (is_mi && hit) ? sat_add(tc, kept) : tc;
    match_count_nxt         = (is_m && hit) ? sat_add(mc, kept) : mc;
    target_pos_nxt          = (is_m || is_d) ? sat_add(tp, s1_item.op_length) : tp;
    inside_window_nxt       = is_mi ? inside_after : win_open;
    target_first_offset_nxt = tfo;
    first_offset_set_nxt    = fos;
    if (is_mi && hit && !fos) begin
      target_first_offset_nxt = sat_add(tp, is_m ? lclip : '0);
      first_offset_set_nxt    = 1'b1;
    end
    if (is_m && hit) begin
      target_kept_nxt = sat_add(tk, kept);
    end else if (is_d && win_open) begin
      target_kept_nxt = sat_add(tk, s1_item.op_length);
    end else begin
      target_kept_nxt = tk;
    end

    trk_nxt.op_valid          = (is_mi && hit) || (is_d && win_open);
    trk_nxt.op_length         = is_d ? s1_item.op_length : kept;
    trk_nxt.op_kind           = s1_item.op_kind;
    trk_nxt.sum_valid         = s1_item.last_op;
    trk_nxt.reverse_strand    = s1_item.reverse_strand;
    trk_nxt.orig_target_start = s1_item.orig_target_start;
    trk_nxt.orig_target_end   = s1_item.orig_target_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r               <= 1'b0;
      query_pos_r           <= '0;
      query_kept_r          <= '0;
      target_pos_r          <= '0;
      target_kept_r         <= '0;
      target_first_offset_r <= '0;
      first_offset_set_r    <= 1'b0;
      inside_window_r       <= 1'b0;
      match_count_r         <= '0;
      total_count_r         <= '0;
    end else begin
      valid_r <= load || (valid_r && !s2_ready);
      if (load) begin
        query_pos_r           <= query_pos_nxt;
        query_kept_r          <= query_kept_nxt;
        target_pos_r          <= target_pos_nxt;
        target_kept_r         <= target_kept_nxt;
        target_first_offset_r <= target_first_offset_nxt;
        first_offset_set_r    <= first_offset_set_nxt;
        inside_window_r       <= inside_window_nxt;
        match_count_r         <= match_count_nxt;
        total_count_r         <= total_count_nxt;
      end
    end
    if (load) begin
      trk_r <= trk_nxt;
    end
  end

  assign s2_valid = valid_r;
  assign s2_trk   = trk_r;

  // The state always belongs to the operation held in this stage.
  assign s2_state.target_first_offset = target_first_offset_r;
  assign s2_state.target_kept         = target_kept_r;
  assign s2_state.match_count         = match_count_r;
  assign s2_state.total_count         = total_count_r;
  assign s2_state.first_offset_set    = first_offset_set_r;

`ifndef ASSERT_OFF
  // The first offset is only ever dropped by the start of a new alignment.
  a_fos_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(first_offset_set_r) |-> $past(load && s1_item.first_op))
    else $error("first offset cleared without a first operation");

  // Matched bases are a subset of the kept bases, saturation included.
  a_match_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    match_count_r <= total_count_r)
    else $error("match count exceeds total count");
`endif

endmodule
`default_nettype wire

// ===== hdl/cwc_out_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cwc_out_stage: summary build and result register
// Holds up to two results per operation and presents them one at a time.
// ----------------------------------------------------------------------------
module cwc_out_stage (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 s2_valid,
  output logic                      s2_ready,
  input  wire cwc_pkg::cwc_trk_t    s2_trk,
  input  wire cwc_pkg::cwc_state_t  s2_state,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [159:0]              out_tdata,
  output logic [3:0]                out_tuser,
  output logic                      out_tlast
);
  import cwc_pkg::*;

  logic            op_v_r, sum_v_r;
  logic [CW-1:0]   op_len_r;
  logic [1:0]      op_kind_r;
  logic [CW-1:0]   ts_r, te_r, mc_r, tc_r;
  logic            err_r;
  logic            load, out_acc;
  logic [CW-1:0]   fwd_ts, fwd_te, rev_ts, rev_te, ts_nxt, te_nxt;

  assign out_tvalid = op_v_r || sum_v_r;
  assign out_acc    = out_tvalid && out_tready;
  assign s2_ready   = !out_tvalid || (out_tready && !(op_v_r && sum_v_r));
  assign load       = s2_valid && s2_ready;

  always_comb begin
    fwd_ts = sat_add(s2_trk.orig_target_start, s2_state.target_first_offset);
    fwd_te = sat_add(fwd_ts, s2_state.target_kept);
    rev_te = sat_sub(s2_trk.orig_target_end, s2_state.target_first_offset);
    rev_ts = sat_sub(rev_te, s2_state.target_kept);
    if (!s2_state.first_offset_set) begin
      ts_nxt = '0;
      te_nxt = '0;
    end else if (s2_trk.reverse_strand) begin
      ts_nxt = rev_ts;
      te_nxt = rev_te;
    end else begin
      ts_nxt = fwd_ts;
      te_nxt = fwd_te;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_v_r  <= 1'b0;
      sum_v_r <= 1'b0;
    end else if (load) begin
      op_v_r  <= s2_trk.op_valid;
      sum_v_r <= s2_trk.sum_valid;
    end else if (out_acc) begin
      if (op_v_r) begin
        op_v_r <= 1'b0;
      end else begin
        sum_v_r <= 1'b0;
      end
    end
    if (load) begin
      op_len_r  <= s2_trk.op_length;
      op_kind_r <= s2_trk.op_kind;
      ts_r      <= ts_nxt;
      te_r      <= te_nxt;
      mc_r      <= s2_state.match_count;
      tc_r      <= s2_state.total_count;
      err_r     <= !s2_state.first_offset_set;
    end
  end

  // The trimmed operation goes first; the summary, when present, closes the item.
  always_comb begin
    if (op_v_r) begin
      out_tdata = {128'd0, op_len_r};
      out_tuser = {1'b0, op_kind_r, RES_OP};
      out_tlast = !sum_v_r;
    end else begin
      out_tdata = {tc_r, mc_r, te_r, ts_r, 32'd0};
      out_tuser = {err_r, KIND_MATCH, RES_SUMMARY};
      out_tlast = 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/cigar_window_clipper.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cigar_window_clipper: clips an alignment operation stream to a query window
// Trims match, insertion and deletion operations to the window and reports the
// clipped target interval with kept base counts after the last operation.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Transaction contents
//  --------+-----------+-----------------------------------------------------
//  in_     | slave     | one alignment operation with its window and target
//  out_    | master    | one trimmed operation or one alignment summary
//
// An operation passes three registered stages: the input register, the
// tracker that updates the running offsets, and the result register.
// While out_tready is high, one operation is accepted per cycle; an
// operation that carries the last flag and also yields a trimmed operation
// occupies the result register for two output transactions, which sets the
// rate at that point.
// Reset is synchronous and active low and clears all stage valids and the
// running alignment state. A stall on out_tready backs up through the stages.
//
module cigar_window_clipper (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  // in_tdata from bit 0: op_length, align_query_start, keep_start, keep_end,
  // orig_target_start, orig_target_end (32 bits each)
  input  wire logic [191:0]  in_tdata,
  // in_tuser from bit 0: first_op, op_kind (2), reverse_strand
  input  wire logic [3:0]    in_tuser,
  input  wire logic          in_tlast,   // last_op
  output logic               out_tvalid,
  input  wire logic          out_tready,
  // out_tdata from bit 0: out_length, new_target_start, new_target_end,
  // match_bases, total_bases (32 bits each)
  output logic [159:0]       out_tdata,
  // out_tuser from bit 0: result_kind, out_kind (2), no_overlap_error
  output logic [3:0]         out_tuser,
  output logic               out_tlast   // last_result
);
  import cwc_pkg::*;

  logic        s1_valid, s1_ready;
  cwc_item_t   s1_item;
  logic        s2_valid, s2_ready;
  cwc_trk_t    s2_trk;
  cwc_state_t  s2_state;

  cwc_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .s1_valid  (s1_valid),
    .s1_ready  (s1_ready),
    .s1_item   (s1_item)
  );

  cwc_tracker u_tracker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_item  (s1_item),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .s2_trk   (s2_trk),
    .s2_state (s2_state)
  );

  cwc_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .s2_valid   (s2_valid),
    .s2_ready   (s2_ready),
    .s2_trk     (s2_trk),
    .s2_state   (s2_state),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef ASSERT_OFF
  // A summary always closes the results of its operation.
  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser[0] == RES_SUMMARY)) |-> out_tlast)
    else $error("summary not marked as last result");

  // With nothing in the window the clipped target interval is empty.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[3]) |-> (out_tdata[95:32] == 64'd0))
    else $error("target interval set with no overlap");
`endif

endmodule
`default_nettype wire
